// ===== sv/tbc_pkg.sv =====
// Shared types, codes and constants of the buffer cache with reuse rings.
package tbc_pkg;

  localparam int DEF_MAX_ENTRIES = 96;
  localparam int DEF_RING_DEPTH  = 256;

  localparam logic [5:0]  TTL_SHORT  = 6'd2;
  localparam logic [5:0]  TTL_LONG   = 6'd60;
  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF0;

  localparam logic [6:0]  RST_G1_COUNT = 7'd48;
  localparam logic [6:0]  RST_TOTAL    = 7'd64;
  localparam logic [12:0] RST_G1_BYTES = 13'd1024;
  localparam logic [12:0] RST_G2_BYTES = 13'd512;
  localparam logic [12:0] MIN_BYTES    = 13'd16;
  localparam logic [12:0] MAX_BYTES    = 13'd4096;

  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_REBUILD = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [1:0] CFG_G1_COUNT = 2'd0;
  localparam logic [1:0] CFG_TOTAL    = 2'd1;
  localparam logic [1:0] CFG_G1_BYTES = 2'd2;
  localparam logic [1:0] CFG_G2_BYTES = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_TICK_INIT,
    OP_TICK_STEP,
    OP_RD_HINT,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_HIT,
    OP_UNL_RD,
    OP_UNL_MOVE,
    OP_TAIL_INC,
    OP_POP_RD1,
    OP_POP_RD2,
    OP_POP,
    OP_ALLOC,
    OP_NOFREE,
    OP_RES_IDLE
  } dp_op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       scan_path;
    logic       scan_more;
    logic       hit;
    logic       need_unlink;
    logic       pos_at_tail;
    logic       r1_ne;
    logic       r2_ne_long;
    logic       idx_ok;
    logic       tick_fin;
    logic       sweep_last;
  } dp_stat_t;

endpackage

// ===== sv/tbc_ctrl.sv =====
// Controller state machine that sequences lookups, ticks and ring rebuilds.
module tbc_ctrl import tbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy,
  output logic     done
);

  typedef enum logic [3:0] {
    S_CLR_INIT,
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_HINT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_UNLINK,
    S_UNL_MOVE,
    S_POP,
    S_ALLOC,
    S_TICK
  } state_t;

  state_t state, state_next;
  logic   report, report_next;
  logic   done_next;
  dp_op_t miss_op;

  always_comb begin
    if (stat.r2_ne_long) begin
      miss_op = OP_POP_RD2;
    end else if (stat.r1_ne) begin
      miss_op = OP_POP_RD1;
    end else begin
      miss_op = OP_NOFREE;
    end
  end

  always_comb begin
    op          = OP_NONE;
    state_next  = state;
    report_next = report;
    done_next   = 1'b0;
    unique case (state)
      S_CLR_INIT: begin
        op         = OP_CLR_INIT;
        state_next = S_CLR;
      end
      S_CLR: begin
        op = OP_CLR_STEP;
        if (stat.sweep_last) begin
          state_next  = S_IDLE;
          done_next   = report;
          report_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          op         = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_TICK: begin
            op         = OP_TICK_INIT;
            state_next = S_TICK;
          end
          ACT_REBUILD: begin
            op          = OP_CLR_INIT;
            report_next = 1'b1;
            state_next  = S_CLR;
          end
          ACT_NONE: begin
            op         = OP_RES_IDLE;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          ACT_LOOKUP: begin
            if (stat.scan_path) begin
              op         = OP_SCAN_INIT;
              state_next = S_SCAN_RD;
            end else begin
              op         = OP_RD_HINT;
              state_next = S_HINT_CHK;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        if (stat.scan_more) begin
          op         = OP_SCAN_RD;
          state_next = S_SCAN_CHK;
        end else begin
          op = miss_op;
          if (miss_op == OP_NOFREE) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_SCAN_CHK: begin
        if (stat.hit) begin
          op         = OP_HIT;
          state_next = S_UNLINK;
        end else if (stat.scan_more) begin
          op = OP_SCAN_RD;
        end else begin
          op = miss_op;
          if (miss_op == OP_NOFREE) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_HINT_CHK: begin
        if (stat.hit) begin
          op         = OP_HIT;
          state_next = S_UNLINK;
        end else begin
          op = miss_op;
          if (miss_op == OP_NOFREE) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_UNLINK: begin
        if (stat.need_unlink && !stat.pos_at_tail) begin
          op         = OP_UNL_RD;
          state_next = S_UNL_MOVE;
        end else begin
          if (stat.need_unlink) begin
            op = OP_TAIL_INC;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UNL_MOVE: begin
        op         = OP_UNL_MOVE;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_POP: begin
        op         = OP_POP;
        state_next = S_ALLOC;
      end
      S_ALLOC: begin
        op         = stat.idx_ok ? OP_ALLOC : OP_NOFREE;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        if (stat.tick_fin) begin
          op         = OP_RES_IDLE;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          op = OP_TICK_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR_INIT;
      report <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
      done   <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/tbc_dpath.sv =====
// Datapath: configuration, entry and ring memories, ring pointers and result registers.
module tbc_dpath import tbc_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int RING_DEPTH  = DEF_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic [1:0]  action,
  input  logic [31:0] dev_addr,
  input  logic [12:0] request_bytes,
  input  logic        long_lived,
  input  logic [6:0]  hint_index,
  input  dp_op_t      op,
  output dp_stat_t    stat,
  output logic [1:0]  status,
  output logic [6:0]  entry_index,
  output logic [11:0] buffer_offset,
  output logic [31:0] fill_dev_addr,
  output logic [12:0] fill_bytes
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int PW    = $clog2(RING_DEPTH);
  localparam int SWEEP = (MAX_ENTRIES > RING_DEPTH) ? MAX_ENTRIES : RING_DEPTH;
  localparam int CW    = $clog2(SWEEP);
  localparam logic [7:0]    MAXE  = 8'(MAX_ENTRIES);
  localparam logic [8:0]    RDEP  = 9'(RING_DEPTH);
  localparam logic [PW-1:0] RLAST = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] SLAST = CW'(SWEEP - 1);

  logic [6:0]  g1_count, total;
  logic [12:0] g1_bytes, g2_bytes;
  logic [1:0]  act;
  logic [31:0] addr;
  logic [12:0] bytes;
  logic        lng;
  logic [6:0]  hint;

  logic [31:0] src_mem [MAX_ENTRIES];
  logic [5:0]  ttl_mem [MAX_ENTRIES];
  logic [PW-1:0] pos_mem [MAX_ENTRIES];
  logic [6:0]  r1_mem [RING_DEPTH];
  logic [6:0]  r2_mem [RING_DEPTH];

  logic [31:0]   src_rd;
  logic [5:0]    ttl_rd;
  logic [PW-1:0] pos_rd;
  logic [6:0]    r1_rd, r2_rd;

  logic [7:0]    cur, walk, tk_idx;
  logic          tk_v, sel;
  logic [6:0]    idx;
  logic [PW-1:0] head1, tail1, head2, tail2;
  logic [PW-1:0] head1_next, tail1_next, head2_next, tail2_next;
  logic [CW-1:0] cnt;
  logic [7:0]    cnt8;

  logic [7:0]  n1, nt, n2;
  logic [12:0] sz1, sz2, size;
  logic [31:0] diff;
  logic        hit;

  logic          ent_re;
  logic [7:0]    ent_raddr;
  logic          src_we, ttl_we, pos_we, r1_we, r2_we;
  logic [7:0]    src_wa, ttl_wa, pos_wa;
  logic [31:0]   src_wd;
  logic [5:0]    ttl_wd;
  logic [PW-1:0] pos_wd, r1_wa, r2_wa;
  logic [6:0]    r1_wd, r2_wd;
  logic [6:0]    moved;

  function automatic logic [12:0] clamp_bytes(input logic [12:0] b);
    if (b < MIN_BYTES) begin
      return MIN_BYTES;
    end else if (b > MAX_BYTES) begin
      return MAX_BYTES;
    end
    return b;
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == RLAST) ? '0 : p + 1'b1;
  endfunction

  assign n1   = ({1'b0, g1_count} > MAXE) ? MAXE : {1'b0, g1_count};
  assign nt   = ({1'b0, total} > MAXE) ? MAXE : {1'b0, total};
  assign n2   = (nt > n1) ? nt - n1 : 8'd0;
  assign sz1  = clamp_bytes(g1_bytes);
  assign sz2  = clamp_bytes(g2_bytes);
  assign cnt8 = 8'(cnt);

  assign size = stat.scan_path ? sz2 : sz1;
  assign diff = addr - src_rd;
  assign hit  = (addr >= src_rd) && (bytes <= size) && (diff <= {19'd0, size - bytes});
  assign moved = stat.scan_path ? r2_rd : r1_rd;

  always_comb begin
    stat.act         = act;
    stat.scan_path   = lng || ({1'b0, hint} >= n1);
    stat.scan_more   = (walk < nt);
    stat.hit         = hit;
    stat.need_unlink = (ttl_rd == 6'd0) &&
                       (stat.scan_path ? (tail2 != head2) : (tail1 != head1));
    stat.pos_at_tail = (pos_rd == (stat.scan_path ? tail2 : tail1));
    stat.r1_ne       = (tail1 != head1);
    stat.r2_ne_long  = lng && (tail2 != head2);
    stat.idx_ok      = ({1'b0, idx} < MAXE);
    stat.tick_fin    = (walk >= nt) && !tk_v;
    stat.sweep_last  = (cnt == SLAST);
  end

  always_comb begin
    ent_re    = 1'b0;
    ent_raddr = walk;
    src_we = 1'b0; src_wa = cur; src_wd = '0;
    ttl_we = 1'b0; ttl_wa = cur; ttl_wd = '0;
    pos_we = 1'b0; pos_wa = cur; pos_wd = '0;
    r1_we  = 1'b0; r1_wa  = head1; r1_wd = '0;
    r2_we  = 1'b0; r2_wa  = head2; r2_wd = '0;
    head1_next = head1; tail1_next = tail1;
    head2_next = head2; tail2_next = tail2;
    case (op)
      OP_CLR_INIT: begin
        head1_next = PW'(n1);
        tail1_next = '0;
        head2_next = PW'(n2);
        tail2_next = '0;
      end
      OP_CLR_STEP: begin
        if ({1'b0, cnt8} < RDEP) begin
          r1_we = 1'b1;
          r1_wa = PW'(cnt);
          r1_wd = (cnt8 < n1) ? cnt8[6:0] : 7'd0;
          r2_we = 1'b1;
          r2_wa = PW'(cnt);
          r2_wd = (cnt8 < n2) ? 7'(n1 + cnt8) : 7'd0;
        end
        if (cnt8 < MAXE) begin
          src_we = 1'b1; src_wa = cnt8; src_wd = '0;
          ttl_we = 1'b1; ttl_wa = cnt8; ttl_wd = '0;
          pos_we = 1'b1; pos_wa = cnt8;
          if (cnt8 < n1) begin
            pos_wd = PW'(cnt8);
          end else if (cnt8 < nt) begin
            pos_wd = PW'(cnt8 - n1);
          end
        end
      end
      OP_RD_HINT: begin
        ent_re    = 1'b1;
        ent_raddr = {1'b0, hint};
      end
      OP_SCAN_RD: begin
        ent_re = 1'b1;
      end
      OP_TICK_STEP: begin
        ent_re = (walk < nt);
        if (tk_v && ttl_rd != 6'd0) begin
          ttl_we = 1'b1;
          ttl_wa = tk_idx;
          ttl_wd = ttl_rd - 6'd1;
          if (ttl_rd == 6'd1) begin
            pos_we = 1'b1;
            pos_wa = tk_idx;
            if (tk_idx < n1) begin
              pos_wd     = head1;
              r1_we      = 1'b1;
              r1_wa      = head1;
              r1_wd      = tk_idx[6:0];
              head1_next = ring_next(head1);
            end else begin
              pos_wd     = head2;
              r2_we      = 1'b1;
              r2_wa      = head2;
              r2_wd      = tk_idx[6:0];
              head2_next = ring_next(head2);
            end
          end
        end
      end
      OP_HIT: begin
        ttl_we = 1'b1;
        ttl_wa = cur;
        ttl_wd = stat.scan_path ? TTL_LONG : TTL_SHORT;
      end
      OP_UNL_MOVE: begin
        pos_we = ({1'b0, moved} < MAXE);
        pos_wa = {1'b0, moved};
        pos_wd = pos_rd;
        if (stat.scan_path) begin
          r2_we      = 1'b1;
          r2_wa      = pos_rd;
          r2_wd      = moved;
          tail2_next = ring_next(tail2);
        end else begin
          r1_we      = 1'b1;
          r1_wa      = pos_rd;
          r1_wd      = moved;
          tail1_next = ring_next(tail1);
        end
      end
      OP_TAIL_INC: begin
        if (stat.scan_path) begin
          tail2_next = ring_next(tail2);
        end else begin
          tail1_next = ring_next(tail1);
        end
      end
      OP_POP: begin
        if (sel) begin
          tail2_next = ring_next(tail2);
        end else begin
          tail1_next = ring_next(tail1);
        end
      end
      OP_ALLOC: begin
        ttl_we = 1'b1; ttl_wa = {1'b0, idx}; ttl_wd = TTL_SHORT;
        src_we = 1'b1; src_wa = {1'b0, idx}; src_wd = addr & ALIGN_MASK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      src_rd <= src_mem[ent_raddr[AW-1:0]];
      ttl_rd <= ttl_mem[ent_raddr[AW-1:0]];
      pos_rd <= pos_mem[ent_raddr[AW-1:0]];
    end
    if (src_we) begin
      src_mem[src_wa[AW-1:0]] <= src_wd;
    end
    if (ttl_we) begin
      ttl_mem[ttl_wa[AW-1:0]] <= ttl_wd;
    end
    if (pos_we) begin
      pos_mem[pos_wa[AW-1:0]] <= pos_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_UNL_RD || op == OP_POP_RD1 || op == OP_POP_RD2) begin
      r1_rd <= r1_mem[tail1];
      r2_rd <= r2_mem[tail2];
    end
    if (r1_we) begin
      r1_mem[r1_wa] <= r1_wd;
    end
    if (r2_we) begin
      r2_mem[r2_wa] <= r2_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_count <= RST_G1_COUNT;
      total    <= RST_TOTAL;
      g1_bytes <= RST_G1_BYTES;
      g2_bytes <= RST_G2_BYTES;
      head1    <= '0;
      tail1    <= '0;
      head2    <= '0;
      tail2    <= '0;
      tk_v     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_G1_COUNT: g1_count <= cfg_wdata[6:0];
          CFG_TOTAL:    total    <= cfg_wdata[6:0];
          CFG_G1_BYTES: g1_bytes <= cfg_wdata;
          CFG_G2_BYTES: g2_bytes <= cfg_wdata;
        endcase
      end
      head1 <= head1_next;
      tail1 <= tail1_next;
      head2 <= head2_next;
      tail2 <= tail2_next;
      if (op == OP_CLR_INIT) begin
        cnt <= '0;
      end else if (op == OP_CLR_STEP) begin
        cnt <= cnt + 1'b1;
      end
      if (op == OP_TICK_INIT) begin
        tk_v <= 1'b0;
      end else if (op == OP_TICK_STEP) begin
        tk_v <= (walk < nt);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        act   <= action;
        addr  <= dev_addr;
        bytes <= request_bytes;
        lng   <= long_lived;
        hint  <= hint_index;
      end
      OP_TICK_INIT: begin
        walk <= 8'd0;
      end
      OP_SCAN_INIT: begin
        walk <= n1;
      end
      OP_SCAN_RD: begin
        cur  <= walk;
        walk <= walk + 8'd1;
      end
      OP_TICK_STEP: begin
        if (walk < nt) begin
          tk_idx <= walk;
          walk   <= walk + 8'd1;
        end
      end
      OP_RD_HINT: begin
        cur <= {1'b0, hint};
      end
      OP_POP_RD1: begin
        sel <= 1'b0;
      end
      OP_POP_RD2: begin
        sel <= 1'b1;
      end
      OP_POP: begin
        idx <= sel ? r2_rd : r1_rd;
      end
      OP_HIT: begin
        status        <= ST_HIT;
        entry_index   <= cur[6:0];
        buffer_offset <= diff[11:0];
        fill_dev_addr <= '0;
        fill_bytes    <= '0;
      end
      OP_ALLOC: begin
        status        <= ST_MISS;
        entry_index   <= idx;
        buffer_offset <= {8'd0, addr[3:0]};
        fill_dev_addr <= addr & ALIGN_MASK;
        fill_bytes    <= ({1'b0, idx} < n1) ? sz1 : sz2;
      end
      OP_NOFREE: begin
        status        <= ST_NOFREE;
        entry_index   <= hint;
        buffer_offset <= '0;
        fill_dev_addr <= '0;
        fill_bytes    <= '0;
      end
      OP_RES_IDLE, OP_CLR_INIT: begin
        status        <= ST_DONE;
        entry_index   <= '0;
        buffer_offset <= '0;
        fill_dev_addr <= '0;
        fill_bytes    <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/ttl_buffer_cache_with_reuse_queues_top.sv =====
// Top level of the buffer cache with reuse rings: controller plus datapath.
// A request is taken when start is high and busy is low; its single result appears for
// exactly one cycle with done high and cannot be stalled. A short lookup that checks
// only the hint entry reads that one entry; a group two lookup walks the group one entry
// per cycle. A tick walks every entry up to entries_total, one per cycle. A ring
// rebuild, and the clearing pass after reset, sweeps the larger of MAX_ENTRIES and
// RING_DEPTH slots of the memories one slot per cycle, with busy high throughout.
// Configuration writes are taken at any time but should only be made while idle.
module ttl_buffer_cache_with_reuse_queues_top import tbc_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int RING_DEPTH  = DEF_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic [1:0]  action,
  input  logic [31:0] dev_addr,
  input  logic [12:0] request_bytes,
  input  logic        long_lived,
  input  logic [6:0]  hint_index,
  output logic [1:0]  status,
  output logic [6:0]  entry_index,
  output logic [11:0] buffer_offset,
  output logic [31:0] fill_dev_addr,
  output logic [12:0] fill_bytes
);

  dp_op_t   op;
  dp_stat_t stat;

  tbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  tbc_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .RING_DEPTH  (RING_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .action        (action),
    .dev_addr      (dev_addr),
    .request_bytes (request_bytes),
    .long_lived    (long_lived),
    .hint_index    (hint_index),
    .op            (op),
    .stat          (stat),
    .status        (status),
    .entry_index   (entry_index),
    .buffer_offset (buffer_offset),
    .fill_dev_addr (fill_dev_addr),
    .fill_bytes    (fill_bytes)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe raised while a request is still in progress.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("Accepted request did not enter the busy phase.");

  a_one_result: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("More than one result for a single request.");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOFREE) |-> (fill_bytes == 13'd0 && buffer_offset == 12'd0))
    else $error("No-free result carries nonzero fill fields.");

endmodule

// ===== tb/sv/tbc_result_checker.sv =====
// Checker for the buffer cache: predicts each result from accepted requests and compares.
module tbc_result_checker import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic [1:0]  action,
  input  logic [31:0] dev_addr,
  input  logic [12:0] request_bytes,
  input  logic        long_lived,
  input  logic [6:0]  hint_index,
  input  logic [1:0]  status,
  input  logic [6:0]  entry_index,
  input  logic [11:0] buffer_offset,
  input  logic [31:0] fill_dev_addr,
  input  logic [12:0] fill_bytes,
  output int          errors,
  output int          outstanding
);

  localparam int NE = DEF_MAX_ENTRIES;

  typedef struct packed {
    logic [1:0]  st;
    logic [6:0]  idx;
    logic [11:0] ofs;
    logic [31:0] faddr;
    logic [12:0] fbytes;
  } lookup_res_t;

  lookup_res_t pending_results[$];

  logic [6:0]  g1_count, total_count;
  logic [12:0] g1_bytes, g2_bytes;
  logic [31:0] src[NE];
  logic [5:0]  ttl[NE];
  logic [7:0]  rpos[NE];
  logic [6:0]  ring1[256];
  logic [6:0]  ring2[256];
  logic [7:0]  r1_head, r1_tail, r2_head, r2_tail;

  function automatic int n_one();
    return (g1_count > NE) ? NE : int'(g1_count);
  endfunction

  function automatic int n_all();
    return (total_count > NE) ? NE : int'(total_count);
  endfunction

  function automatic logic [12:0] size_of(int i);
    logic [12:0] b;
    b = (i < n_one()) ? g1_bytes : g2_bytes;
    if (b < MIN_BYTES) return MIN_BYTES;
    if (b > MAX_BYTES) return MAX_BYTES;
    return b;
  endfunction

  function automatic bit fits(int i, logic [31:0] a, logic [12:0] n);
    logic [31:0] p;
    logic [12:0] sz;
    sz = size_of(i);
    if (a < src[i]) return 0;
    p = a - src[i];
    if (n > sz) return 0;
    return p <= 32'(sz - n);
  endfunction

  task automatic relayout();
    int n1, nt;
    n1 = n_one();
    nt = n_all();
    for (int i = 0; i < NE; i++) begin
      src[i] = '0;
      ttl[i] = '0;
      rpos[i] = '0;
    end
    for (int i = 0; i < 256; i++) begin
      ring1[i] = '0;
      ring2[i] = '0;
    end
    for (int i = 0; i < n1; i++) begin
      ring1[i] = 7'(i);
      rpos[i] = 8'(i);
    end
    r1_head = 8'(n1);
    r1_tail = '0;
    r2_head = '0;
    for (int i = n1; i < nt; i++) begin
      ring2[8'(i - n1)] = 7'(i);
      rpos[i] = 8'(i - n1);
      r2_head = 8'(i - n1 + 1);
    end
    r2_tail = '0;
  endtask

  task automatic age_all();
    int n1;
    n1 = n_one();
    for (int i = 0; i < n_all(); i++) begin
      if (ttl[i] != 0) begin
        ttl[i]--;
        if (ttl[i] == 0) begin
          if (i < n1) begin
            rpos[i] = r1_head;
            ring1[r1_head] = 7'(i);
            r1_head++;
          end else begin
            rpos[i] = r2_head;
            ring2[r2_head] = 7'(i);
            r2_head++;
          end
        end
      end
    end
  endtask

  task automatic unlink_one(int i);
    logic [6:0] moved;
    if (r1_tail == r1_head) return;
    if (rpos[i] != r1_tail) begin
      moved = ring1[r1_tail];
      ring1[rpos[i]] = moved;
      if (moved < NE) rpos[moved] = rpos[i];
    end
    r1_tail++;
  endtask

  task automatic unlink_two(int i);
    logic [6:0] moved;
    if (r2_tail == r2_head) return;
    if (rpos[i] != r2_tail) begin
      moved = ring2[r2_tail];
      ring2[rpos[i]] = moved;
      if (moved < NE) rpos[moved] = rpos[i];
    end
    r2_tail++;
  endtask

  task automatic cache_predict(input logic [1:0] act, input logic [31:0] a,
                               input logic [12:0] n, input logic ll,
                               input logic [6:0] hint, output lookup_res_t r);
    int n1, nt, victim;
    bit got;
    n1 = n_one();
    nt = n_all();
    got = 0;
    victim = 0;
    r = '0;
    r.st = ST_DONE;
    if (act == ACT_TICK) begin
      age_all();
      return;
    end
    if (act == ACT_REBUILD) begin
      relayout();
      return;
    end
    if (act == ACT_NONE) return;
    if (ll || hint >= n1) begin
      for (int i = n1; i < nt; i++) begin
        if (fits(i, a, n)) begin
          if (ttl[i] == 0) unlink_two(i);
          ttl[i] = TTL_LONG;
          r.st = ST_HIT;
          r.idx = 7'(i);
          r.ofs = 12'(a - src[i]);
          return;
        end
      end
      if (ll && r2_tail != r2_head) begin
        victim = ring2[r2_tail];
        r2_tail++;
        got = 1;
      end
    end else if (fits(hint, a, n)) begin
      if (ttl[hint] == 0) unlink_one(hint);
      ttl[hint] = TTL_SHORT;
      r.st = ST_HIT;
      r.idx = hint;
      r.ofs = 12'(a - src[hint]);
      return;
    end
    if (!got && r1_tail != r1_head) begin
      victim = ring1[r1_tail];
      r1_tail++;
      got = 1;
    end
    if (!got || victim >= NE) begin
      r.st = ST_NOFREE;
      r.idx = hint;
      return;
    end
    ttl[victim] = TTL_SHORT;
    src[victim] = a & ALIGN_MASK;
    r.st = ST_MISS;
    r.idx = 7'(victim);
    r.ofs = 12'(a[3:0]);
    r.faddr = a & ALIGN_MASK;
    r.fbytes = size_of(victim);
  endtask

  task automatic report(input string what, input logic [31:0] got_v,
                        input logic [31:0] want_v);
    $display("mismatch %s: got %0h, predicted %0h at %0t", what, got_v, want_v, $time);
    errors++;
  endtask

  initial errors = 0;
  assign outstanding = pending_results.size();

  always @(posedge clk) begin
    lookup_res_t w;
    if (rst) begin
      g1_count = RST_G1_COUNT;
      total_count = RST_TOTAL;
      g1_bytes = RST_G1_BYTES;
      g2_bytes = RST_G2_BYTES;
      relayout();
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report("unrequested result", 32'(status), 32'(ST_DONE));
        end else begin
          w = pending_results.pop_front();
          if (status != w.st) report("status", 32'(status), 32'(w.st));
          if (entry_index != w.idx) report("entry_index", 32'(entry_index), 32'(w.idx));
          if (buffer_offset != w.ofs) report("buffer_offset", 32'(buffer_offset), 32'(w.ofs));
          if (fill_dev_addr != w.faddr) report("fill_dev_addr", fill_dev_addr, w.faddr);
          if (fill_bytes != w.fbytes) report("fill_bytes", 32'(fill_bytes), 32'(w.fbytes));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_G1_COUNT: g1_count = cfg_wdata[6:0];
          CFG_TOTAL:    total_count = cfg_wdata[6:0];
          CFG_G1_BYTES: g1_bytes = cfg_wdata;
          CFG_G2_BYTES: g2_bytes = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        cache_predict(action, dev_addr, request_bytes, long_lived, hint_index, w);
        pending_results.push_back(w);
      end
    end
  end

endmodule

// ===== tb/sv/ttl_buffer_cache_with_reuse_queues_top_test.sv =====
// Testbench top of the buffer cache: drives requests and configuration, gives the verdict.
module ttl_buffer_cache_with_reuse_queues_top_test;
  import tbc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk, rst, start, busy, done, cfg_we, long_lived;
  logic [1:0]  cfg_index, action, status;
  logic [12:0] cfg_wdata, request_bytes, fill_bytes;
  logic [31:0] dev_addr, fill_dev_addr;
  logic [6:0]  hint_index, entry_index;
  logic [11:0] buffer_offset;
  int          errors, outstanding, quiet_cycles;
  logic [31:0] recent_addr[8];
  logic [6:0]  last_hint;

  ttl_buffer_cache_with_reuse_queues_top u_top (.*);
  tbc_result_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (done) last_hint <= entry_index;
  end

  task automatic send(input logic [1:0] act, input logic [31:0] a, input logic [12:0] n,
                      input logic ll, input logic [6:0] hint);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= act;
    dev_addr <= a;
    request_bytes <= n;
    long_lived <= ll;
    hint_index <= hint;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    recent_addr[$urandom_range(0, 7)] = a;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] a;
    logic [12:0] n;
    pick = $urandom_range(0, 99);
    a = recent_addr[$urandom_range(0, 7)] + $urandom_range(0, 700) - 64;
    n = 13'($urandom_range(0, 300));
    if ($urandom_range(0, 9) == 0) n = 13'($urandom_range(0, 4096));
    if ($urandom_range(0, 9) == 0) a = $urandom;
    if (pick < 65) begin
      send(ACT_LOOKUP, a, n, 1'($urandom_range(0, 2) == 0),
           ($urandom_range(0, 1) != 0) ? last_hint : 7'($urandom_range(0, 95)));
    end else if (pick < 90) begin
      send(ACT_TICK, $urandom, 13'($urandom_range(0, 4096)), 1'($urandom), 7'($urandom_range(0, 95)));
    end else if (pick < 96) begin
      send(ACT_REBUILD, $urandom, 13'($urandom_range(0, 4096)), 1'($urandom), 7'($urandom_range(0, 95)));
    end else begin
      send(ACT_NONE, $urandom, 13'($urandom_range(0, 4096)), 1'($urandom), 7'($urandom_range(0, 95)));
    end
  endtask

  task automatic set_config(input logic [12:0] c1, input logic [12:0] ct,
                            input logic [12:0] b1, input logic [12:0] b2);
    drain();
    write_reg(CFG_G1_COUNT, c1);
    write_reg(CFG_TOTAL, ct);
    write_reg(CFG_G1_BYTES, b1);
    write_reg(CFG_G2_BYTES, b2);
    @(posedge clk);
    send(ACT_REBUILD, '0, '0, 1'b0, '0);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    action <= ACT_LOOKUP;
    dev_addr <= '0;
    request_bytes <= '0;
    long_lived <= 1'b0;
    hint_index <= '0;
    for (int i = 0; i < 8; i++) recent_addr[i] = $urandom_range(0, 8192);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_LOOKUP, 32'h0000_1234, 13'd16, 1'b0, 7'd0);
    send(ACT_LOOKUP, 32'h0000_1238, 13'd8, 1'b0, last_hint);
    send(ACT_LOOKUP, 32'h0000_1230, 13'd4096, 1'b0, last_hint);
    send(ACT_LOOKUP, 32'hFFFF_FFFF, 13'd0, 1'b1, 7'd95);
    send(ACT_LOOKUP, 32'hFFFF_FFFF, 13'd1, 1'b1, 7'd95);
    send(ACT_LOOKUP, 32'hFFFF_FFF0, 13'd0, 1'b0, 7'd64);
    send(ACT_LOOKUP, 32'h0000_0000, 13'd0, 1'b0, 7'd47);
    send(ACT_LOOKUP, 32'h0000_0000, 13'd1024, 1'b0, 7'd47);
    send(ACT_TICK, '0, '0, 1'b0, '0);
    send(ACT_TICK, '1, 13'd4096, 1'b1, 7'd95);
    send(ACT_LOOKUP, 32'h0000_1234, 13'd16, 1'b0, 7'd0);
    send(ACT_NONE, 32'hA5A5_5A5A, 13'd4095, 1'b1, 7'd42);
    send(ACT_REBUILD, '0, '0, 1'b0, '0);
    for (int i = 0; i < 50; i++) send(ACT_LOOKUP, 32'(i * 4096), 13'd1, 1'b0, 7'd0);
    send(ACT_LOOKUP, 32'h0080_0000, 13'd1, 1'b0, 7'd0);

    set_config(13'd96, 13'd96, 13'd4096, 13'd4096);
    send(ACT_LOOKUP, 32'h0000_2000, 13'd0, 1'b1, 7'd0);
    send(ACT_LOOKUP, 32'h0000_3000, 13'd0, 1'b1, 7'd0);
    send(ACT_LOOKUP, 32'h0000_3000, 13'd0, 1'b0, 7'd5);
    for (int i = 0; i < 150; i++) random_request();

    set_config(13'd0, 13'd0, 13'd0, 13'd0);
    for (int i = 0; i < 60; i++) random_request();

    set_config(13'd10, 13'd30, 13'd4096, 13'd16);
    for (int i = 0; i < 180; i++) random_request();
    drain();
    for (int i = 0; i < 40; i++) random_request();

    set_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd8);
    for (int i = 0; i < 120; i++) random_request();

    set_config(13'd40, 13'd20, 13'd256, 13'd2048);
    for (int i = 0; i < 150; i++) random_request();

    set_config(13'd48, 13'd64, 13'd1024, 13'd512);
    for (int i = 0; i < 150; i++) random_request();

    set_config(13'd3, 13'd96, 13'd32, 13'd64);
    for (int i = 0; i < 200; i++) random_request();

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
